// ----- sv/hrs_pkg.sv -----
`timescale 1ns / 1ps

package hrs_pkg;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 11;
    localparam int RATIO_W = 20;
    localparam int OWID_W  = 12;
    localparam int Q_W     = 17;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [Q_W-1:0] ONE_Q16 = 17'h1_0000;

    // register index, taken from paddr[2]
    localparam logic REG_SCALE_RATIO = 1'b0;
    localparam logic REG_OUT_WIDTH   = 1'b1;

    typedef struct packed {
        logic [RATIO_W-1:0] scale_ratio;
        logic [OWID_W-1:0]  out_width;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic [COL_W-1:0] out_column;
        logic             last_of_run;
    } t_res;

endpackage

// ----- sv/hrs_pix_if.sv -----
`timescale 1ns / 1ps

interface hrs_pix_if;
    logic                     valid;
    logic                     ready;
    logic [hrs_pkg::PIX_W-1:0] in_red;
    logic [hrs_pkg::PIX_W-1:0] in_green;
    logic [hrs_pkg::PIX_W-1:0] in_blue;
    logic                     row_end;

    modport source (output valid, in_red, in_green, in_blue, row_end, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, row_end, output ready);
endinterface

// ----- sv/hrs_res_if.sv -----
`timescale 1ns / 1ps

interface hrs_res_if;
    logic                     valid;
    logic                     ready;
    logic [hrs_pkg::PIX_W-1:0] out_red;
    logic [hrs_pkg::PIX_W-1:0] out_green;
    logic [hrs_pkg::PIX_W-1:0] out_blue;
    logic [hrs_pkg::COL_W-1:0] out_column;
    logic                     last_of_run;

    modport source (output valid, out_red, out_green, out_blue, out_column, last_of_run,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_column, last_of_run,
                    output ready);
endinterface

// ----- sv/hrs_mac.sv -----
`timescale 1ns / 1ps

// one channel: sum + floor(weight * pix / 2^16), saturated at 255
module hrs_mac (
    input  logic [hrs_pkg::PIX_W-1:0] i_sum,
    input  logic [hrs_pkg::Q_W-1:0]   i_weight,
    input  logic [hrs_pkg::PIX_W-1:0] i_pix,
    output logic [hrs_pkg::PIX_W-1:0] o_sum
);

    logic [hrs_pkg::Q_W+hrs_pkg::PIX_W-1:0] w_prod;
    logic [hrs_pkg::PIX_W+1:0]              w_acc;

    assign w_prod = i_weight * i_pix;
    assign w_acc  = {2'b00, i_sum} + {1'b0, w_prod[hrs_pkg::Q_W+hrs_pkg::PIX_W-1:16]};
    assign o_sum  = (w_acc > 10'd255) ? 8'hFF : w_acc[hrs_pkg::PIX_W-1:0];

endmodule

// ----- sv/hrs_cfg.sv -----
`timescale 1ns / 1ps

module hrs_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hrs_pkg::ADDR_W-1:0] paddr,
    input  logic [hrs_pkg::DATA_W-1:0] pwdata,
    output logic [hrs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output hrs_pkg::t_cfg              o_cfg
);

    hrs_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_ratio <= 20'd65536;
            r_cfg.out_width   <= 12'd2048;
        end else if (w_wr) begin
            case (paddr[2])
                hrs_pkg::REG_SCALE_RATIO: r_cfg.scale_ratio <= pwdata[hrs_pkg::RATIO_W-1:0];
                hrs_pkg::REG_OUT_WIDTH:   r_cfg.out_width   <= pwdata[hrs_pkg::OWID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            hrs_pkg::REG_SCALE_RATIO:
                prdata = {{(hrs_pkg::DATA_W-hrs_pkg::RATIO_W){1'b0}}, r_cfg.scale_ratio};
            hrs_pkg::REG_OUT_WIDTH:
                prdata = {{(hrs_pkg::DATA_W-hrs_pkg::OWID_W){1'b0}}, r_cfg.out_width};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ----- sv/horizontal_area_resampler_top.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// i_pix     in   valid / ready    in_red, in_green, in_blue, row_end
// o_res     out  valid / ready    out_red, out_green, out_blue, out_column, last_of_run
// apb       in   psel / penable   paddr 3 bits, pwdata / prdata 32 bits, pready tied high
//
// a pixel beat steps through accept, then for every weight slice a check and three channel
// steps, an emit step for every output it completes, then row-end and finish steps;
// a row-end flush adds an extra emit step, a slice check that finds the row full skips its
// three channel steps; the three channels share one multiply-add-saturate unit
// results wait one slice in a holding register so last_of_run is known; a stalled
// output beat holds the sequencer in its emit or finish step
// reset is synchronous, active low; it restores the register defaults and opens a fresh row
module horizontal_area_resampler_top #(
    parameter int MAX_ROW_WIDTH = 2048,
    parameter int MAX_UPSCALE   = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hrs_pix_if.sink                    i_pix,
    hrs_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hrs_pkg::ADDR_W-1:0] paddr,
    input  logic [hrs_pkg::DATA_W-1:0] pwdata,
    output logic [hrs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    // column counter must hold the row limit itself
    localparam int CNT_W = $clog2(MAX_ROW_WIDTH + 1);
    localparam int CMP_W = (CNT_W > hrs_pkg::OWID_W) ? CNT_W : hrs_pkg::OWID_W;
    // ratio cap, MAX_UPSCALE * 1.0 minus one lsb
    localparam logic [21:0] RATIO_CAP = 22'(MAX_UPSCALE * 65536 - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MAC,
        S_EMIT,
        S_ROWEND,
        S_FIN
    } t_state;

    hrs_pkg::t_cfg w_cfg;

    t_state                       r_state;
    logic [hrs_pkg::PIX_W-1:0]    r_pix [3];
    logic [hrs_pkg::PIX_W-1:0]    r_sum [3];
    logic                         r_last;
    logic [hrs_pkg::RATIO_W-1:0]  r_avail;
    logic [CNT_W-1:0]             r_limit;
    logic [CNT_W-1:0]             r_count;
    logic [hrs_pkg::Q_W-1:0]      r_need;
    logic [hrs_pkg::Q_W-1:0]      r_slice;
    logic                         r_full;
    logic [1:0]                   r_ch;
    logic                         r_flush;
    hrs_pkg::t_res                r_pend;
    logic                         r_pend_valid;
    hrs_pkg::t_res                r_out;
    logic                         r_out_valid;

    logic [hrs_pkg::RATIO_W-1:0]  w_avail_cap;
    logic [CNT_W-1:0]             w_limit;
    logic                         w_full;
    logic                         w_out_free;
    logic                         w_out_load;
    logic [hrs_pkg::PIX_W-1:0]    w_mac;

    hrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // shared channel unit, walked over red, green, blue
    hrs_mac u_mac (
        .i_sum    (r_sum[r_ch]),
        .i_weight (r_slice),
        .i_pix    (r_pix[r_ch]),
        .o_sum    (w_mac)
    );

    // clamp ratio and row width at pixel accept
    assign w_avail_cap = ({2'b00, w_cfg.scale_ratio} > RATIO_CAP) ?
                         RATIO_CAP[hrs_pkg::RATIO_W-1:0] : w_cfg.scale_ratio;
    assign w_limit     = (CMP_W'(w_cfg.out_width) > CMP_W'(MAX_ROW_WIDTH)) ?
                         CNT_W'(MAX_ROW_WIDTH) : CNT_W'(w_cfg.out_width);

    // remaining weight covers the open output's need
    assign w_full     = (r_avail >= hrs_pkg::RATIO_W'(r_need));
    assign w_out_free = !r_out_valid || o_res.ready;
    // held result moves to the output register in the emit or finish step
    assign w_out_load = r_pend_valid && w_out_free &&
                        ((r_state == S_EMIT) || (r_state == S_FIN));

    assign i_pix.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.out_red     = r_out.out_red;
    assign o_res.out_green   = r_out.out_green;
    assign o_res.out_blue    = r_out.out_blue;
    assign o_res.out_column  = r_out.out_column;
    assign o_res.last_of_run = r_out.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_need       <= hrs_pkg::ONE_Q16;
            r_sum[0]     <= '0;
            r_sum[1]     <= '0;
            r_sum[2]     <= '0;
            r_ch         <= '0;
            r_flush      <= 1'b0;
        end else begin
            // output beat reloaded, or taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pix.valid) begin
                        r_pix[0] <= i_pix.in_red;
                        r_pix[1] <= i_pix.in_green;
                        r_pix[2] <= i_pix.in_blue;
                        r_last   <= i_pix.row_end;
                        r_avail  <= w_avail_cap;
                        r_limit  <= w_limit;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // row full: pixel only matters for its row end
                    if (r_count < r_limit) begin
                        r_slice <= w_full ? r_need : r_avail[hrs_pkg::Q_W-1:0];
                        r_full  <= w_full;
                        r_ch    <= '0;
                        r_state <= S_MAC;
                    end else begin
                        r_state <= S_ROWEND;
                    end
                end
                S_MAC: begin
                    r_sum[r_ch] <= w_mac;
                    if (r_ch == 2'd2) begin
                        if (r_full) begin
                            r_avail <= r_avail - hrs_pkg::RATIO_W'(r_need);
                            r_flush <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            // partial slice, avail is below need here
                            r_need  <= r_need - r_avail[hrs_pkg::Q_W-1:0];
                            r_state <= S_ROWEND;
                        end
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
                S_EMIT: begin
                    // older result leaves the holding register, not last of its run
                    if (!r_pend_valid || w_out_free) begin
                        if (r_pend_valid) begin
                            r_out.out_red     <= r_pend.out_red;
                            r_out.out_green   <= r_pend.out_green;
                            r_out.out_blue    <= r_pend.out_blue;
                            r_out.out_column  <= r_pend.out_column;
                            r_out.last_of_run <= 1'b0;
                        end
                        r_pend.out_red     <= r_sum[0];
                        r_pend.out_green   <= r_sum[1];
                        r_pend.out_blue    <= r_sum[2];
                        r_pend.out_column  <= hrs_pkg::COL_W'(r_count);
                        r_pend.last_of_run <= 1'b0;
                        r_pend_valid       <= 1'b1;
                        r_need             <= hrs_pkg::ONE_Q16;
                        r_sum[0]           <= '0;
                        r_sum[1]           <= '0;
                        r_sum[2]           <= '0;
                        if (r_flush) begin
                            r_count <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_ROWEND: begin
                    if (r_last) begin
                        // flush a partly filled output, else just clear the row
                        if (r_count < r_limit && r_need < hrs_pkg::ONE_Q16) begin
                            r_flush <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_count  <= '0;
                            r_need   <= hrs_pkg::ONE_Q16;
                            r_sum[0] <= '0;
                            r_sum[1] <= '0;
                            r_sum[2] <= '0;
                            r_state  <= S_FIN;
                        end
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // held result is the last of this pixel's run
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out.out_red     <= r_pend.out_red;
                        r_out.out_green   <= r_pend.out_green;
                        r_out.out_blue    <= r_pend.out_blue;
                        r_out.out_column  <= r_pend.out_column;
                        r_out.last_of_run <= 1'b1;
                        r_pend_valid      <= 1'b0;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// self-checking bench for the horizontal area resampler
// pixel beats are driven through the source side of the pixel channel, result beats are
// taken from the result channel with random back-pressure, and every accepted pixel is run
// through a bit-exact copy of the resampling rules to predict the result beats it causes
module tb;

    localparam int CLK_PERIOD  = 20;
    localparam int ROW_CAP     = 2048;
    localparam int UPSCALE_CAP = 16;
    localparam int MAX_BURST   = 17;
    // worst case time for one pixel to work through all of its slices, plus margin
    localparam int SETTLE_CYCLES = 7 + 5 * MAX_BURST + 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_WAIT      = 14;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 40;

    typedef struct packed {
        logic [hrs_pkg::PIX_W-1:0] red;
        logic [hrs_pkg::PIX_W-1:0] green;
        logic [hrs_pkg::PIX_W-1:0] blue;
        logic                      row_end;
    } t_pixel;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    hrs_pix_if pix_bus ();
    hrs_res_if res_bus ();

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [hrs_pkg::ADDR_W-1:0] paddr;
    logic [hrs_pkg::DATA_W-1:0] pwdata;
    logic [hrs_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    horizontal_area_resampler_top #(
        .MAX_ROW_WIDTH(ROW_CAP),
        .MAX_UPSCALE  (UPSCALE_CAP)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_bus),
        .o_res  (res_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow of the configuration registers
    logic [hrs_pkg::RATIO_W-1:0] ratio_q;
    logic [hrs_pkg::OWID_W-1:0]  width_q;

    // shadow of the row state: open output and column position
    logic [hrs_pkg::Q_W-1:0]    need_q;
    logic [hrs_pkg::PIX_W-1:0]  acc_red;
    logic [hrs_pkg::PIX_W-1:0]  acc_green;
    logic [hrs_pkg::PIX_W-1:0]  acc_blue;
    logic [hrs_pkg::OWID_W-1:0] col_q;

    hrs_pkg::t_res expected_outputs[$];
    hrs_pkg::t_res exp_res;

    int  error_count   = 0;
    int  stall_cycles  = 0;
    bit  src_quiet     = 1'b0;
    bit  sink_quiet    = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_open_output();
        need_q    = hrs_pkg::ONE_Q16;
        acc_red   = '0;
        acc_green = '0;
        acc_blue  = '0;
    endfunction

    function automatic void predictor_reset();
        ratio_q = 20'd65536;
        width_q = 12'd2048;
        col_q   = '0;
        clear_open_output();
    endfunction

    // add one truncated partial product to a channel sum, saturating at full scale
    function automatic logic [hrs_pkg::PIX_W-1:0] weighted_add(
        logic [hrs_pkg::PIX_W-1:0]   acc,
        logic [hrs_pkg::RATIO_W-1:0] weight,
        logic [hrs_pkg::PIX_W-1:0]   level
    );
        logic [31:0] prod;
        logic [31:0] total;
        prod  = 32'(weight) * 32'(level);
        total = 32'(acc) + (prod >> 16);
        return (total > 32'd255) ? 8'hFF : total[hrs_pkg::PIX_W-1:0];
    endfunction

    function automatic void pour_slice(logic [hrs_pkg::RATIO_W-1:0] weight, t_pixel px);
        acc_red   = weighted_add(acc_red, weight, px.red);
        acc_green = weighted_add(acc_green, weight, px.green);
        acc_blue  = weighted_add(acc_blue, weight, px.blue);
    endfunction

    function automatic void emit_output();
        hrs_pkg::t_res res;
        res.out_red     = acc_red;
        res.out_green   = acc_green;
        res.out_blue    = acc_blue;
        res.out_column  = col_q[hrs_pkg::COL_W-1:0];
        res.last_of_run = 1'b0;
        expected_outputs.push_back(res);
        col_q = col_q + 1'b1;
        clear_open_output();
    endfunction

    // queue the result beats one accepted pixel causes
    function automatic void resample_pixel(t_pixel px);
        logic [hrs_pkg::OWID_W-1:0]  limit;
        logic [hrs_pkg::RATIO_W-1:0] avail;
        int                          first;
        bit                          filling;
        hrs_pkg::t_res               tail;
        limit   = (width_q > hrs_pkg::OWID_W'(ROW_CAP)) ? hrs_pkg::OWID_W'(ROW_CAP) : width_q;
        avail   = (ratio_q > hrs_pkg::RATIO_W'(UPSCALE_CAP * 65536 - 1)) ?
                  hrs_pkg::RATIO_W'(UPSCALE_CAP * 65536 - 1) : ratio_q;
        first   = expected_outputs.size();
        filling = 1'b1;
        while (filling && col_q < limit) begin
            if (avail >= hrs_pkg::RATIO_W'(need_q)) begin
                // slice meets the need: close this output and carry the rest on
                pour_slice(hrs_pkg::RATIO_W'(need_q), px);
                avail = avail - hrs_pkg::RATIO_W'(need_q);
                emit_output();
            end else begin
                pour_slice(avail, px);
                need_q  = need_q - avail[hrs_pkg::Q_W-1:0];
                filling = 1'b0;
            end
        end
        if (px.row_end) begin
            // flush a partly filled output unless it got nothing or the row is full
            if (col_q < limit && need_q < hrs_pkg::ONE_Q16) begin
                emit_output();
            end
            col_q = '0;
            clear_open_output();
        end
        if (expected_outputs.size() > first) begin
            tail = expected_outputs.pop_back();
            tail.last_of_run = 1'b1;
            expected_outputs.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_outputs.size() == 0) begin
                // nothing predicted, so any beat here is spurious
                $display("%0t: unexpected result beat, expected none, actual column %0d",
                         $time, res_bus.out_column);
                error_count++;
            end else begin
                exp_res = expected_outputs.pop_front();
                check_field("out_red", exp_res.out_red, res_bus.out_red);
                check_field("out_green", exp_res.out_green, res_bus.out_green);
                check_field("out_blue", exp_res.out_blue, res_bus.out_blue);
                check_field("out_column", exp_res.out_column, res_bus.out_column);
                check_field("last_of_run", exp_res.last_of_run, res_bus.last_of_run);
            end
        end
    end

    // watchdog: any beat or register access counts as progress
    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure: a fresh stall drawn for every result beat
    initial begin : sink_pacing
        int hold;
        res_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = sink_quiet ? 0 : $urandom_range(MAX_WAIT, 0);
            if (hold > 0) begin
                res_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // present one pixel beat after a random gap; returns at the accepting edge
    task automatic send_pixel(t_pixel px);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(MAX_WAIT, 0);
        if (gap > 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid    <= 1'b1;
        pix_bus.in_red   <= px.red;
        pix_bus.in_green <= px.green;
        pix_bus.in_blue  <= px.blue;
        pix_bus.row_end  <= px.row_end;
        do @(posedge i_clk); while (!(pix_bus.valid && pix_bus.ready));
        resample_pixel(px);
    endtask

    // drop valid, drain every predicted beat, then give the sequencer time to go quiet
    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup phase, access phase, then the bus is released
    task automatic write_reg(logic idx, logic [hrs_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == hrs_pkg::REG_SCALE_RATIO) begin
            ratio_q = value[hrs_pkg::RATIO_W-1:0];
        end else begin
            width_q = value[hrs_pkg::OWID_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // junk fills the unused upper bits of the write data
    task automatic configure(logic [hrs_pkg::RATIO_W-1:0] ratio,
                             logic [hrs_pkg::OWID_W-1:0] width, bit junk);
        logic [hrs_pkg::DATA_W-1:0] upper;
        wait_idle();
        upper = junk ? hrs_pkg::DATA_W'($urandom) : '0;
        write_reg(hrs_pkg::REG_SCALE_RATIO,
                  {upper[hrs_pkg::DATA_W-1:hrs_pkg::RATIO_W], ratio});
        write_reg(hrs_pkg::REG_OUT_WIDTH,
                  {upper[hrs_pkg::DATA_W-1:hrs_pkg::OWID_W], width});
    endtask

    task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic row_end);
        t_pixel px;
        px = {r, g, b, row_end};
        send_pixel(px);
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // reset values: unit ratio, every pixel fills exactly one output
    task automatic test_unit_ratio();
        send_rgb(8'h00, 8'h00, 8'h00, 1'b0);
        send_rgb(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_rgb(8'hA5, 8'h5A, 8'h0F, 1'b1);
    endtask

    // half ratio: two pixels per output, odd row leaves a partial output to flush
    task automatic test_downscale_flush();
        configure(20'h08000, 12'd2048, 1'b0);
        send_rgb(8'hFF, 8'h00, 8'h80, 1'b0);
        send_rgb(8'h01, 8'hFE, 8'h7F, 1'b0);
        send_rgb(8'hC8, 8'h64, 8'h32, 1'b1);
    endtask

    // largest ratio: one pixel spreads over sixteen outputs
    task automatic test_max_upscale();
        configure(20'hFFFFF, 12'd2048, 1'b0);
        send_rgb(8'hFF, 8'h80, 8'h01, 1'b1);
        send_rgb(8'h07, 8'h08, 8'h09, 1'b0);
        send_rgb(8'h0A, 8'h0B, 8'h0C, 1'b1);
    endtask

    // full row drops the rest, and a width above the row cap is clamped
    task automatic test_row_full();
        configure(20'h20000, 12'd3, 1'b0);
        send_rgb(8'h10, 8'h20, 8'h30, 1'b0);
        send_rgb(8'h40, 8'h50, 8'h60, 1'b0);
        send_rgb(8'h70, 8'h80, 8'h90, 1'b0);
        send_rgb(8'hA0, 8'hB0, 8'hC0, 1'b1);
        configure(20'h10000, 12'hFFF, 1'b0);
        send_rgb(8'h33, 8'h66, 8'h99, 1'b0);
        send_rgb(8'hCC, 8'hEE, 8'h11, 1'b1);
    endtask

    // zero width: no output at all
    task automatic test_zero_width();
        configure(20'h10000, 12'd0, 1'b0);
        send_rgb(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_rgb(8'h12, 8'h34, 8'h56, 1'b1);
    endtask

    // zero ratio: no weight, nothing completes and nothing is flushed
    task automatic test_zero_ratio();
        configure(20'h00000, 12'd2048, 1'b0);
        send_rgb(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_rgb(8'h00, 8'hFF, 8'h00, 1'b0);
        send_rgb(8'h80, 8'h80, 8'h80, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // random rows
    // ------------------------------------------------------------------

    // channel level biased toward the extremes
    function automatic logic [hrs_pkg::PIX_W-1:0] pick_level();
        case ($urandom_range(7, 0))
            0: return 8'h00;
            1: return 8'hFF;
            default: return hrs_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic test_random_rows();
        logic [hrs_pkg::RATIO_W-1:0] ratio;
        logic [hrs_pkg::OWID_W-1:0]  width;
        t_pixel                      px;
        int                          row_len;
        int                          sent;
        bit                          broken;
        for (int phase = 0; phase < PHASES; phase++) begin
            // first two phases pin the register extremes
            if (phase == 0) begin
                ratio = 20'd1;
                width = 12'd1;
            end else if (phase == 1) begin
                ratio = 20'hFFFFF;
                width = 12'hFFF;
            end else begin
                case ($urandom_range(4, 0))
                    0: ratio = hrs_pkg::RATIO_W'($urandom_range(4095, 1));
                    1: ratio = hrs_pkg::RATIO_W'($urandom_range(65535, 4096));
                    2: ratio = hrs_pkg::RATIO_W'($urandom_range(131072, 65536));
                    3: ratio = hrs_pkg::RATIO_W'($urandom_range(20'hFFFFF, 131073));
                    default: ratio = 20'h10000;
                endcase
                case ($urandom_range(7, 0))
                    0, 1, 2: width = hrs_pkg::OWID_W'($urandom_range(6, 1));
                    3, 4, 5: width = hrs_pkg::OWID_W'($urandom_range(2048, 7));
                    6: width = hrs_pkg::OWID_W'($urandom_range(4095, 2049));
                    default: width = '0;
                endcase
            end
            configure(ratio, width, 1'b1);
            sink_quiet = ($urandom_range(3, 0) == 0);
            sent       = 0;
            while (sent < PHASE_ITEMS) begin
                // mostly clean rows; a few carry stray row ends in the middle
                row_len   = $urandom_range(12, 1);
                broken    = ($urandom_range(7, 0) == 0);
                src_quiet = ($urandom_range(3, 0) == 0);
                for (int k = 0; k < row_len; k++) begin
                    px.red     = pick_level();
                    px.green   = pick_level();
                    px.blue    = pick_level();
                    px.row_end = (k == row_len - 1) || (broken && $urandom_range(2, 0) == 0);
                    send_pixel(px);
                    sent++;
                end
            end
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        pix_bus.valid    = 1'b0;
        pix_bus.in_red   = '0;
        pix_bus.in_green = '0;
        pix_bus.in_blue  = '0;
        pix_bus.row_end  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        predictor_reset();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unit_ratio();
        test_downscale_flush();
        test_max_upscale();
        test_row_full();
        test_zero_width();
        test_zero_ratio();
        test_random_rows();

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
